/* design/bmhq_pkg.sv */
// Package for the binary max-heap priority queue.
// Holds the entry type, command and status codes and the sequencer states.
// No dependencies.
package bmhq_pkg;

  localparam int KEY_W = 16;
  localparam int TAG_W = 16;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_EXTRACTED = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CHECK,
    S_UP_CMP,
    S_DN_LOAD,
    S_DN_CHECK,
    S_DN_CMP,
    S_FINISH
  } state_t;

endpackage

/* design/binary_max_heap_queue.sv */
// Binary max-heap priority queue: an insert adds a keyed word, an extract
// returns the word with the highest key. Entries sit in one synchronous RAM.
// Depends on bmhq_pkg.
//
// Usage:
// An input word (command, priority_key, payload_tag) is taken when in_valid
// is high and in_stall is low. Each input word gives exactly one output word
// (status, out_key, out_payload, entry_count), presented with out_valid and
// held until out_stall is low. out_key and out_payload are zero unless an
// extract succeeds.
// The block works on one word at a time; in_stall is high while it does.
// An insert climbs the heap level by level until its key no longer exceeds its
// parent's or it reaches the root. An extract moves the last entry to the root
// and lets it sink level by level until no child's key exceeds its own or it
// ends at a leaf. Each level costs one RAM read (the parent, or both children
// at once) and one compare with write-back. The next word is taken only once
// the result has moved into the output register.
// Full inserts and empty extracts change nothing.
// A finished result waits in the output register while the next word is
// taken; that next word completes only once the waiting result has left.
// Reset empties the queue at once; the RAM needs no clearing.
module binary_max_heap_queue
  import bmhq_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     command,
  input  logic [KEY_W-1:0]         priority_key,
  input  logic [TAG_W-1:0]         payload_tag,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               status,
  output logic [KEY_W-1:0]         out_key,
  output logic [TAG_W-1:0]         out_payload,
  output logic [7:0]               entry_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  entry_t heap_mem [CAPACITY];
  entry_t rd0;
  entry_t rd1;
  logic [AW-1:0] ra0;
  logic [AW-1:0] ra1;
  logic          we;
  logic [AW-1:0] wa;
  entry_t        wd;

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] pos, pos_next;
  entry_t        item, item_next;
  logic [1:0]    res_status, res_status_next;
  entry_t        res_entry, res_entry_next;
  logic          out_load;

  logic [CW:0]   left_pos;
  logic [CW:0]   count_ext;
  logic          right_ok;
  logic          left_wins;
  logic          right_wins;
  logic [KEY_W-1:0] left_best_key;

  always_ff @(posedge clk) begin
    if (we) begin
      heap_mem[wa] <= wd;
    end
    rd0 <= heap_mem[ra0];
    rd1 <= heap_mem[ra1];
  end

  assign in_stall      = (state != S_IDLE);
  assign left_pos      = {pos, 1'b0};
  assign count_ext     = {1'b0, count};
  assign right_ok      = ({pos, 1'b1} <= count_ext);
  assign left_wins     = (rd0.key > item.key);
  assign left_best_key = left_wins ? rd0.key : item.key;
  assign right_wins    = right_ok && (rd1.key > left_best_key);
  assign out_load      = (state == S_FINISH) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= (out_valid && out_stall) || out_load;
    end
    pos        <= pos_next;
    item       <= item_next;
    res_status <= res_status_next;
    res_entry  <= res_entry_next;
    if (out_load) begin
      status      <= res_status;
      out_key     <= res_entry.key;
      out_payload <= res_entry.tag;
      entry_count <= 8'(count);
    end
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    pos_next        = pos;
    item_next       = item;
    res_status_next = res_status;
    res_entry_next  = res_entry;
    we              = 1'b0;
    wa              = AW'(pos - 1'b1);
    wd              = item;
    ra0             = AW'(left_pos - 1'b1);
    ra1             = (left_pos < count_ext) ? AW'(left_pos) : AW'(left_pos - 1'b1);
    case (state)
      S_IDLE: begin
        ra0 = '0;
        ra1 = AW'(count - 1'b1);
        if (in_valid) begin
          res_entry_next = '0;
          if (command == CMD_INSERT) begin
            if (count == CW'(CAPACITY)) begin
              res_status_next = ST_FULL;
              state_next      = S_FINISH;
            end else begin
              res_status_next = ST_INSERTED;
              item_next       = '{key: priority_key, tag: payload_tag};
              pos_next        = count + 1'b1;
              count_next      = count + 1'b1;
              state_next      = S_UP_CHECK;
            end
          end else begin
            if (count == '0) begin
              res_status_next = ST_EMPTY;
              state_next      = S_FINISH;
            end else begin
              res_status_next = ST_EXTRACTED;
              count_next      = count - 1'b1;
              state_next      = S_DN_LOAD;
            end
          end
        end
      end
      S_UP_CHECK: begin
        ra0 = AW'((pos >> 1) - 1'b1);
        if (pos == CW'(1)) begin
          we         = 1'b1;
          state_next = S_FINISH;
        end else begin
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (item.key > rd0.key) begin
          wd         = rd0;
          pos_next   = pos >> 1;
          state_next = S_UP_CHECK;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_DN_LOAD: begin
        res_entry_next = rd0;
        item_next      = rd1;
        pos_next       = CW'(1);
        state_next     = S_DN_CHECK;
      end
      S_DN_CHECK: begin
        if (left_pos > count_ext) begin
          we         = 1'b1;
          state_next = S_FINISH;
        end else begin
          state_next = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (right_wins) begin
          wd         = rd1;
          pos_next   = CW'(left_pos + 1'b1);
          state_next = S_DN_CHECK;
        end else if (left_wins) begin
          wd         = rd0;
          pos_next   = CW'(left_pos);
          state_next = S_DN_CHECK;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* design/bmhq_checker.sv */
// Port-level checker for the binary max-heap priority queue, bound to the top level.
// Depends on bmhq_pkg and binary_max_heap_queue.
module bmhq_checker
  import bmhq_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             command,
  input logic [KEY_W-1:0] priority_key,
  input logic [TAG_W-1:0] payload_tag,
  input logic             out_valid,
  input logic             out_stall,
  input logic [1:0]       status,
  input logic [KEY_W-1:0] out_key,
  input logic [TAG_W-1:0] out_payload,
  input logic [7:0]       entry_count
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid &&
      $stable({command, priority_key, payload_tag}))
    else $error("Stalled input word changed.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid &&
      $stable({status, out_key, out_payload, entry_count}))
    else $error("Stalled output word changed.");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_EXTRACTED |-> out_key == '0 && out_payload == '0)
    else $error("Key or payload set on a word that is not an extract.");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> entry_count == 8'd0)
    else $error("Empty extract reported a nonzero count.");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> entry_count == 8'(CAPACITY))
    else $error("Full insert reported a count below capacity.");

endmodule

bind binary_max_heap_queue bmhq_checker #(.CAPACITY(CAPACITY)) u_bmhq_checker (.*);
